// ===== hw/rtl/ssms_pkg.sv =====
package ssms_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int PRICE_W = 32;
	localparam int DAY_W = 32;
	localparam int SPAN_W = 32;

	localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic first_day;
	} item_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic inexact;
	} result_t;

	typedef struct packed {
		logic valid;
		logic [PRICE_W-1:0] price;
		logic [DAY_W-1:0] day;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic pop;
		logic push;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ===== hw/rtl/stock_span_monotonic_stack.sv =====
// after a request is accepted the scan state pops entries, then pushes the request and registers its result
// no new request is taken until the current one is pushed; the top cell compares and pops one entry a cycle
// each request is pushed once and popped at most once; the push waits while the result output stalls
// reset: clears cell valid bits, day counter, overflow record and handshake state
// cell payloads are not reset and need no clearing pass
module stock_span_monotonic_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ssms_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ssms_pkg::result_t result
);

	localparam int N = ssms_pkg::STACK_DEPTH;

	ssms_pkg::state_t state_q, state_next;
	ssms_pkg::cell_ctl_t ctl;
	ssms_pkg::entry_t stack_entry [N];
	ssms_pkg::entry_t new_entry;
	ssms_pkg::entry_t empty_entry;

	logic [ssms_pkg::PRICE_W-1:0] price_q;
	logic [ssms_pkg::DAY_W-1:0] day_q;
	logic lost_q;
	logic [ssms_pkg::DAY_W-1:0] last_disc_q;
	logic out_valid_q;
	ssms_pkg::result_t out_q;

	logic accept;
	logic pop_ok;
	logic out_free;
	logic [ssms_pkg::DAY_W-1:0] diff;
	ssms_pkg::result_t res_next;

	assign accept = item_valid && !item_stall;
	assign pop_ok = stack_entry[0].valid && (stack_entry[0].price <= price_q);
	assign out_free = !out_valid_q || !result_stall;

	assign new_entry.valid = 1'b1;
	assign new_entry.price = price_q;
	assign new_entry.day = day_q;

	assign empty_entry.valid = 1'b0;
	assign empty_entry.price = '0;
	assign empty_entry.day = '0;

	// cell chain, index 0 is the top of stack
	for (genvar i = 0; i < N; i++) begin : g_cell
		ssms_pkg::entry_t above_i;
		ssms_pkg::entry_t below_i;
		if (i == 0) begin : g_top
			assign above_i = new_entry;
		end else begin : g_mid_a
			assign above_i = stack_entry[i-1];
		end
		if (i == N - 1) begin : g_bot
			assign below_i = empty_entry;
		end else begin : g_mid_b
			assign below_i = stack_entry[i+1];
		end
		ssms_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.above (above_i),
			.below (below_i),
			.entry (stack_entry[i])
		);
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ssms_pkg::ST_IDLE: begin
				if (accept) begin
					state_next = ssms_pkg::ST_SCAN;
				end
			end
			ssms_pkg::ST_SCAN: begin
				if (!pop_ok && out_free) begin
					state_next = ssms_pkg::ST_IDLE;
				end
			end
			default: state_next = ssms_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall = 1'b1;
		ctl = '0;
		case (state_q)
			ssms_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				ctl.clear = item_valid && item.first_day;
			end
			ssms_pkg::ST_SCAN: begin
				ctl.pop = pop_ok;
				ctl.push = !pop_ok && out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// span of the current request
	always_comb begin
		res_next.inexact = 1'b0;
		if (stack_entry[0].valid) begin
			diff = day_q - stack_entry[0].day;
		end else if (lost_q) begin
			diff = day_q - last_disc_q;
			res_next.inexact = 1'b1;
		end else if (day_q == ssms_pkg::DAY_MAX) begin
			diff = ssms_pkg::DAY_MAX;
		end else begin
			diff = day_q + 1'b1;
		end
		res_next.span = (diff == '0) ? ssms_pkg::SPAN_W'(1) : ssms_pkg::SPAN_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssms_pkg::ST_IDLE;
			day_q <= '0;
			lost_q <= 1'b0;
			last_disc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.clear) begin
				day_q <= '0;
				lost_q <= 1'b0;
				last_disc_q <= '0;
			end else if (ctl.push) begin
				if (day_q != ssms_pkg::DAY_MAX) begin
					day_q <= day_q + 1'b1;
				end
				// bottom cell falls off
				if (stack_entry[N-1].valid) begin
					lost_q <= 1'b1;
					last_disc_q <= stack_entry[N-1].day;
				end
			end
			if (ctl.push) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= item.price;
		end
		if (ctl.push) begin
			out_q <= res_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ===== hw/rtl/ssms_cell.sv =====
module ssms_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ssms_pkg::cell_ctl_t ctl,
	input  ssms_pkg::entry_t  above,
	input  ssms_pkg::entry_t  below,
	output ssms_pkg::entry_t  entry
);

	logic valid_q;
	logic [ssms_pkg::PRICE_W-1:0] price_q;
	logic [ssms_pkg::DAY_W-1:0] day_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= below.valid;
		end else if (ctl.push) begin
			valid_q <= above.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			price_q <= below.price;
			day_q <= below.day;
		end else if (ctl.push) begin
			price_q <= above.price;
			day_q <= above.day;
		end
	end

	assign entry.valid = valid_q;
	assign entry.price = price_q;
	assign entry.day = day_q;

endmodule

// ===== tb/sv/stock_span_monotonic_stack_tb.sv =====
module stock_span_monotonic_stack_tb;

	localparam int TARGET_REQS = 1300;
	localparam int TAIL_REQS = 150;
	localparam int HOLD_AT = 500;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = ssms_pkg::STACK_DEPTH + 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	ssms_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	ssms_pkg::result_t result;

	stock_span_monotonic_stack dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// request list and drain-before flags
	ssms_pkg::item_t price_reqs[$];
	bit drain_before[$];
	ssms_pkg::result_t span_expect_q[$];

	// predictor state
	logic [ssms_pkg::PRICE_W-1:0] stk_price[ssms_pkg::STACK_DEPTH];
	logic [ssms_pkg::DAY_W-1:0] stk_day[ssms_pkg::STACK_DEPTH];
	int stk_count = 0;
	logic [ssms_pkg::DAY_W-1:0] day_num = '0;
	bit dropped = 1'b0;
	logic [ssms_pkg::DAY_W-1:0] dropped_day = '0;

	int next_req = 0;
	int sent_count = 0;
	int results_seen = 0;
	int errors = 0;
	int send_gap = 0;
	int send_idle_pct = 10;
	int stall_left = 0;
	int hold_left = 0;
	int recv_idle_pct = 10;
	bit long_hold_done = 1'b0;

	function automatic int pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	function automatic ssms_pkg::result_t predict_span(input ssms_pkg::item_t req);
		ssms_pkg::result_t r;
		logic [ssms_pkg::DAY_W-1:0] today;
		logic [ssms_pkg::SPAN_W-1:0] s;
		if (req.first_day) begin
			stk_count = 0;
			day_num = '0;
			dropped = 1'b0;
			dropped_day = '0;
		end
		today = day_num;
		r.inexact = 1'b0;
		while (stk_count > 0 && stk_price[stk_count-1] <= req.price)
			stk_count--;
		if (stk_count > 0) begin
			s = today - stk_day[stk_count-1];
		end else if (dropped) begin
			s = today - dropped_day;
			r.inexact = 1'b1;
		end else begin
			s = (today == ssms_pkg::DAY_MAX) ? ssms_pkg::DAY_MAX : today + 1;
		end
		if (s == 0)
			s = 1;
		// full stack: drop the bottom entry
		if (stk_count >= ssms_pkg::STACK_DEPTH) begin
			dropped_day = stk_day[0];
			dropped = 1'b1;
			for (int i = 0; i < ssms_pkg::STACK_DEPTH - 1; i++) begin
				stk_price[i] = stk_price[i+1];
				stk_day[i] = stk_day[i+1];
			end
			stk_count = ssms_pkg::STACK_DEPTH - 1;
		end
		stk_price[stk_count] = req.price;
		stk_day[stk_count] = today;
		stk_count++;
		if (day_num != ssms_pkg::DAY_MAX)
			day_num++;
		r.span = s;
		return r;
	endfunction

	task automatic add_req(input logic [ssms_pkg::PRICE_W-1:0] p, input logic fd,
			input bit drain);
		ssms_pkg::item_t r;
		r.price = p;
		r.first_day = fd;
		price_reqs.insert(price_reqs.size(), r);
		drain_before.insert(drain_before.size(), drain);
	endtask

	initial begin
		int kind;
		int len;
		logic [ssms_pkg::PRICE_W-1:0] p;
		// directed series
		add_req(32'd100, 1'b1, 1'b0);
		add_req(32'd50, 1'b0, 1'b0);
		add_req(32'd50, 1'b0, 1'b0);
		add_req(32'd75, 1'b0, 1'b0);
		add_req(32'd0, 1'b0, 1'b0);
		add_req(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_req(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_req(32'd0, 1'b1, 1'b1);
		add_req(32'd0, 1'b0, 1'b0);
		add_req(32'd1, 1'b0, 1'b0);
		add_req(32'h8000_0000, 1'b0, 1'b0);
		add_req(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_req(32'h5555_5555, 1'b0, 1'b0);
		add_req(32'hAAAA_AAAA, 1'b0, 1'b0);
		add_req(32'd3, 1'b0, 1'b0);
		add_req(32'd2, 1'b1, 1'b0);
		add_req(32'd2, 1'b0, 1'b0);
		// random segments, the first one always overflows the stack
		while (price_reqs.size() < TARGET_REQS) begin
			if (price_reqs.size() < 30 || $urandom_range(29) == 0) begin
				p = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
				add_req(p, 1'($urandom_range(1)), $urandom_range(3) == 0);
				len = ssms_pkg::STACK_DEPTH + $urandom_range(24, 1);
				repeat (len) begin
					p = p - $urandom_range(1000, 1);
					add_req(p, 1'b0, 1'b0);
				end
				repeat ($urandom_range(4))
					add_req(p - $urandom_range(2000), 1'b0, 1'b0);
				// clears the stack past the dropped entries
				add_req(32'hFFFF_FFFF, 1'b0, 1'b0);
				repeat ($urandom_range(3))
					add_req($urandom, 1'b0, 1'b0);
			end else begin
				kind = $urandom_range(3);
				len = $urandom_range(40, 1);
				p = $urandom;
				for (int i = 0; i < len; i++) begin
					case (kind)
						0: add_req($urandom_range(7), i == 0 && $urandom_range(1),
							i == 0 && $urandom_range(9) == 0);
						1: add_req($urandom, i == 0 && $urandom_range(1),
							i == 0 && $urandom_range(9) == 0);
						2: begin
							if ($urandom_range(1))
								p = p + $urandom_range(255);
							else
								p = p - $urandom_range(255);
							add_req(p, i == 0 && $urandom_range(1),
								i == 0 && $urandom_range(9) == 0);
						end
						default: add_req($urandom_range(1) ? $urandom : $urandom_range(15),
							$urandom_range(5) == 0, 1'b0);
					endcase
				end
			end
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		ssms_pkg::result_t pred;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				pred = predict_span(item);
				span_expect_q.insert(span_expect_q.size(), pred);
				sent_count++;
				if (sent_count % 100 == 0)
					send_idle_pct = pick_idle_pct();
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (next_req >= price_reqs.size()) begin
					item_valid <= 1'b0;
				end else if (drain_before[next_req] && span_expect_q.size() != 0) begin
					item_valid <= 1'b0;
				end else if (sent_count + TAIL_REQS < price_reqs.size()
						&& $urandom_range(99) < send_idle_pct) begin
					send_gap = $urandom_range(15);
					item_valid <= 1'b0;
				end else begin
					item <= price_reqs[next_req];
					item_valid <= 1'b1;
					next_req++;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		ssms_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (span_expect_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual span %0d inexact %0b",
						$time, result.span, result.inexact);
					errors++;
				end else begin
					want = span_expect_q.pop_front();
					if (result.span !== want.span) begin
						$display("%0t: span mismatch: expected %0d, actual %0d",
							$time, want.span, result.span);
						errors++;
					end
					if (result.inexact !== want.inexact) begin
						$display("%0t: inexact mismatch: expected %0b, actual %0b",
							$time, want.inexact, result.inexact);
						errors++;
					end
				end
				results_seen++;
				if (results_seen % 100 == 0)
					recv_idle_pct = pick_idle_pct();
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!long_hold_done && results_seen >= HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (results_seen + TAIL_REQS < price_reqs.size()
					&& $urandom_range(99) < recv_idle_pct) begin
				stall_left = $urandom_range(15);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (sent_count < price_reqs.size() || span_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("stock_span_monotonic_stack test passed");
		else
			$display("stock_span_monotonic_stack test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("stock_span_monotonic_stack test failed");
		$finish;
	end

endmodule
